>>> design/bsc_pkg.sv
package bsc_pkg;

    localparam int DataW = 32;
    localparam int RawW = 20;
    localparam int NumCal = 6;
    localparam int CfgIdxW = 3;

    localparam logic [2:0] REG_T1_T2 = 3'd0;
    localparam logic [2:0] REG_T3_P1 = 3'd1;
    localparam logic [2:0] REG_P2_P3 = 3'd2;
    localparam logic [2:0] REG_P4_P5 = 3'd3;
    localparam logic [2:0] REG_P6_P7 = 3'd4;
    localparam logic [2:0] REG_P8_P9 = 3'd5;

    // Sign-extend a 16-bit coefficient to 32 bits
    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    // Low 32 bits of a 32x32 product
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul32 = p[31:0];
    endfunction

endpackage

>>> design/bsc_div.sv
// Pipelined unsigned 32/32 divider, one quotient bit per stage
module bsc_div
    import bsc_pkg::*;
#(
    parameter int SideW = 32
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [31:0]      dividend,
    input  logic [31:0]      divisor,
    input  logic [SideW-1:0] side_in,
    output logic [31:0]      quotient,
    output logic [SideW-1:0] side_out
);

    logic [31:0] rem_reg [0:30];
    logic [31:0] quo_reg [0:31];
    logic [31:0] dvs_reg [0:30];
    logic [SideW-1:0] side_reg [0:31];

    // Restoring division, one stage per bit
    for (genvar s = 0; s < 32; s++)
    begin : g_stage
        logic [31:0] rem_cur;
        logic [31:0] quo_cur;
        logic [31:0] dvs_cur;
        logic [SideW-1:0] side_cur;
        logic [32:0] trial;
        logic [32:0] diff;

        // Select the stage input: pipeline inputs for the first stage
        if (s == 0)
        begin : g_first
            assign rem_cur = 32'd0;
            assign quo_cur = dividend;
            assign dvs_cur = divisor;
            assign side_cur = side_in;
        end
        else
        begin : g_next
            assign rem_cur = rem_reg[s-1];
            assign quo_cur = quo_reg[s-1];
            assign dvs_cur = dvs_reg[s-1];
            assign side_cur = side_reg[s-1];
        end

        always_comb
        begin
            trial = {rem_cur, quo_cur[31]};
            diff = trial - {1'b0, dvs_cur};
        end

        // Advance quotient bits and side data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= {quo_cur[30:0], !diff[32]};
                side_reg[s] <= side_cur;
            end
        end

        // Carry the partial remainder and divisor to the next stage
        if (s < 31)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= diff[32] ? trial[31:0] : diff[31:0];
                    dvs_reg[s] <= dvs_cur;
                end
            end
        end
    end

    assign quotient = quo_reg[31];
    assign side_out = side_reg[31];

endmodule

>>> design/baro_sensor_compensation.sv
// Barometric compensation pipeline. Takes one raw temperature/pressure pair per
// cycle while the output is not stalled and returns one result per transaction
// through 10 arithmetic stages, 6 alignment stages, a 32-stage restoring
// pressure divider, and 3 correction stages. Back-pressure on the output stalls
// the whole pipeline in place.
// Calibration registers may be written only while the pipeline is empty.
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [39:0]        s_axis_tdata,  // raw_temp[19:0], raw_press[39:20]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [95:0]        m_axis_tdata,  // temperature, fine_temp, pressure
    output logic               m_axis_tuser,  // div_zero
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DataW-1:0]   cfg_data
);

    localparam int NPre = 16;
    localparam int NDiv = 32;
    localparam int NPost = 3;
    localparam int NTot = NPre + NDiv + NPost;

    logic [31:0] cal_reg [0:NumCal-1];
    logic [NTot-1:0] vld_reg;
    logic en;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = vld_reg[NTot-1];

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumCal; i++)
                cal_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_index < CfgIdxW'(NumCal))
        begin
            cal_reg[cfg_index] <= cfg_data;
        end
    end

    // Valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NTot-2:0], s_axis_tvalid};
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, cal_reg[REG_T1_T2][15:0]};
    assign t2 = sx16(cal_reg[REG_T1_T2][31:16]);
    assign t3 = sx16(cal_reg[REG_T3_P1][15:0]);
    assign p1 = {16'd0, cal_reg[REG_T3_P1][31:16]};
    assign p2 = sx16(cal_reg[REG_P2_P3][15:0]);
    assign p3 = sx16(cal_reg[REG_P2_P3][31:16]);
    assign p4 = sx16(cal_reg[REG_P4_P5][15:0]);
    assign p5 = sx16(cal_reg[REG_P4_P5][31:16]);
    assign p6 = sx16(cal_reg[REG_P6_P7][15:0]);
    assign p7 = sx16(cal_reg[REG_P6_P7][31:16]);
    assign p8 = sx16(cal_reg[REG_P8_P9][15:0]);
    assign p9 = sx16(cal_reg[REG_P8_P9][31:16]);

    logic [31:0] ut, up;
    assign ut = {12'd0, s_axis_tdata[19:0]};
    assign up = {12'd0, s_axis_tdata[39:20]};

    // Stage registers (payload)
    logic [31:0] s1_x_reg, s1_d_reg, s1_up_reg;
    logic [31:0] s2_a_reg, s2_dd_reg, s2_up_reg;
    logic [31:0] s3_a_reg, s3_b_reg, s3_up_reg;
    logic [31:0] s4_fine_reg, s4_up_reg;
    logic [31:0] s5_fine_reg, s5_t5_reg, s5_a_reg, s5_q_reg, s5_up_reg;
    logic [31:0] s6_fine_reg, s6_temp_reg, s6_a_reg, s6_qq_reg, s6_up_reg;
    logic [31:0] s7_fine_reg, s7_temp_reg, s7_b6_reg, s7_b5_reg, s7_c3_reg, s7_c2_reg,
                 s7_up_reg;
    logic [31:0] s8_fine_reg, s8_temp_reg, s8_b_reg, s8_an_reg, s8_up_reg;
    logic [31:0] s9_fine_reg, s9_temp_reg, s9_m_reg, s9_ad_reg;
    logic [31:0] s10_fine_reg, s10_temp_reg, s10_p_reg, s10_ad_reg;

    // Keep the arithmetic shifts apart from unsigned operands
    logic [31:0] s5_half;
    logic [31:0] st3_b, st3_bq, s8_b, s8_an, s9_m;
    assign s5_half = $signed(s4_fine_reg) >>> 1;
    assign st3_b = s7_b6_reg + (s7_b5_reg << 1);
    assign st3_bq = $signed(st3_b) >>> 2;
    assign s8_b = $signed(st3_bq + (p4 << 16)) >>> 12;
    assign s8_an = $signed(($signed(s7_c3_reg) >>> 3) + ($signed(s7_c2_reg) >>> 1)) >>> 18;
    assign s9_m = (32'd1048576 - s8_up_reg) - s8_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Temperature terms
            s1_x_reg <= (ut >> 3) - (t1 << 1);
            s1_d_reg <= (ut >> 4) - t1;
            s1_up_reg <= up;
            s2_a_reg <= $signed(mul32(s1_x_reg, t2)) >>> 11;
            s2_dd_reg <= $signed(mul32(s1_d_reg, s1_d_reg)) >>> 12;
            s2_up_reg <= s1_up_reg;
            s3_a_reg <= s2_a_reg;
            s3_b_reg <= $signed(mul32(s2_dd_reg, t3)) >>> 14;
            s3_up_reg <= s2_up_reg;
            s4_fine_reg <= s3_a_reg + s3_b_reg;
            s4_up_reg <= s3_up_reg;
            // Fine temperature fan-out
            s5_fine_reg <= s4_fine_reg;
            s5_t5_reg <= mul32(s4_fine_reg, 32'd5) + 32'd128;
            s5_a_reg <= s5_half - 32'd64000;
            s5_q_reg <= s5_half - 32'd64000;
            s5_up_reg <= s4_up_reg;
            s6_fine_reg <= s5_fine_reg;
            s6_temp_reg <= $signed(s5_t5_reg) >>> 8;
            s6_a_reg <= s5_a_reg;
            s6_qq_reg <= mul32($signed(s5_q_reg) >>> 2, $signed(s5_q_reg) >>> 2);
            s6_up_reg <= s5_up_reg;
            // Pressure products
            s7_fine_reg <= s6_fine_reg;
            s7_temp_reg <= s6_temp_reg;
            s7_b6_reg <= mul32($signed(s6_qq_reg) >>> 11, p6);
            s7_b5_reg <= mul32(s6_a_reg, p5);
            s7_c3_reg <= mul32(p3, $signed(s6_qq_reg) >>> 13);
            s7_c2_reg <= mul32(p2, s6_a_reg);
            s7_up_reg <= s6_up_reg;
            s8_fine_reg <= s7_fine_reg;
            s8_temp_reg <= s7_temp_reg;
            s8_b_reg <= s8_b;
            s8_an_reg <= s8_an;
            s8_up_reg <= s7_up_reg;
            s9_fine_reg <= s8_fine_reg;
            s9_temp_reg <= s8_temp_reg;
            s9_m_reg <= s9_m;
            s9_ad_reg <= $signed(mul32(32'd32768 + s8_an_reg, p1)) >>> 15;
            s10_fine_reg <= s9_fine_reg;
            s10_temp_reg <= s9_temp_reg;
            s10_p_reg <= mul32(s9_m_reg, 32'd3125);
            s10_ad_reg <= s9_ad_reg;
        end
    end

    // Align to NPre stages before the divider
    // Layout from bit 0: dividend, large-dividend flag, zero divisor,
    // fine, temperature, divisor
    localparam int DlyN = NPre - 10;
    localparam int SideW = 32 + 32 + 1 + 1;
    localparam int DlyW = 32 + SideW + 32;
    logic [DlyW-1:0] dly_reg [0:DlyN-1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= {s10_ad_reg, s10_temp_reg, s10_fine_reg,
                           s10_ad_reg == 32'd0, s10_p_reg[31], s10_p_reg};
            for (int i = 1; i < DlyN; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    logic [31:0] dv_den, dv_num, dv_q;
    logic [SideW-1:0] dv_side_in, dv_side_out;
    assign dv_den = dly_reg[DlyN-1][DlyW-1 -: 32];
    assign dv_side_in = dly_reg[DlyN-1][SideW+31:32];
    assign dv_num = dly_reg[DlyN-1][32] ? dly_reg[DlyN-1][31:0]
                                        : (dly_reg[DlyN-1][31:0] << 1);

    bsc_div #(.SideW(SideW)) u_div (
        .clk      (clk),
        .en       (en),
        .dividend (dv_num),
        .divisor  (dv_den),
        .side_in  (dv_side_in),
        .quotient (dv_q),
        .side_out (dv_side_out)
    );

    // Post-division correction
    logic [31:0] pq;
    logic [31:0] c1_p_reg, c1_temp_reg, c1_fine_reg, c1_sq_reg, c1_b_reg;
    logic c1_dz_reg;
    logic [31:0] c2_p_reg, c2_temp_reg, c2_fine_reg, c2_a_reg, c2_b_reg;
    logic c2_dz_reg;
    logic [31:0] c3_p_reg, c3_temp_reg, c3_fine_reg;
    logic c3_dz_reg;
    logic [31:0] c2_corr;
    assign pq = dv_side_out[0] ? (dv_q << 1) : dv_q;
    assign c2_corr = $signed(c2_a_reg + c2_b_reg + p7) >>> 4;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_p_reg <= pq;
            c1_temp_reg <= dv_side_out[65:34];
            c1_fine_reg <= dv_side_out[33:2];
            c1_dz_reg <= dv_side_out[1];
            c1_sq_reg <= mul32(pq >> 3, pq >> 3) >> 13;
            c1_b_reg <= $signed(mul32(pq >> 2, p8)) >>> 13;
            c2_p_reg <= c1_p_reg;
            c2_temp_reg <= c1_temp_reg;
            c2_fine_reg <= c1_fine_reg;
            c2_dz_reg <= c1_dz_reg;
            c2_a_reg <= $signed(mul32(p9, c1_sq_reg)) >>> 12;
            c2_b_reg <= c1_b_reg;
            c3_temp_reg <= c2_temp_reg;
            c3_fine_reg <= c2_fine_reg;
            c3_dz_reg <= c2_dz_reg;
            c3_p_reg <= c2_dz_reg ? 32'd0 : c2_p_reg + c2_corr;
        end
    end

    assign m_axis_tdata = {c3_p_reg, c3_fine_reg, c3_temp_reg};
    assign m_axis_tuser = c3_dz_reg;

endmodule

>>> tb/tb_top.sv
module tb_top
    import bsc_pkg::*;
();

    localparam int Latency = 51;
    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles = 2 * Latency + 20;
    localparam int HoldCycles = 300;

    typedef struct packed {
        logic [19:0] raw_press;
        logic [19:0] raw_temp;
    } sample_t;

    typedef struct packed {
        logic [31:0] temperature;
        logic [31:0] fine_temp;
        logic [31:0] pressure;
        logic        div_zero;
    } comp_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [DataW-1:0] cfg_data;

    baro_sensor_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Calibration shadow and scoreboard
    logic [31:0] cal_shadow [NumCal];
    sample_t     sample_q[$];
    comp_t       comp_expect_q[$];
    int          err_count = 0;
    int          sent_count = 0;
    int          recv_count = 0;
    int          div_zero_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cnt;
    logic        hold_req;
    logic        hold_done;
    int          settle_wait;
    logic        cfg_busy;
    logic        sent_fire;
    logic        recv_fire;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] shr_s(input logic [31:0] x, input int n);
        shr_s = $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] mlo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        mlo = p[31:0];
    endfunction

    // Compensate one raw sample with the shadowed coefficients
    function automatic comp_t compensate(input sample_t s);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] ut, up, a, b, d, q, qq, fine, temp, press, sq;
        comp_t r;
        t1 = {16'd0, cal_shadow[REG_T1_T2][15:0]};
        t2 = {{16{cal_shadow[REG_T1_T2][31]}}, cal_shadow[REG_T1_T2][31:16]};
        t3 = {{16{cal_shadow[REG_T3_P1][15]}}, cal_shadow[REG_T3_P1][15:0]};
        p1 = {16'd0, cal_shadow[REG_T3_P1][31:16]};
        p2 = {{16{cal_shadow[REG_P2_P3][15]}}, cal_shadow[REG_P2_P3][15:0]};
        p3 = {{16{cal_shadow[REG_P2_P3][31]}}, cal_shadow[REG_P2_P3][31:16]};
        p4 = {{16{cal_shadow[REG_P4_P5][15]}}, cal_shadow[REG_P4_P5][15:0]};
        p5 = {{16{cal_shadow[REG_P4_P5][31]}}, cal_shadow[REG_P4_P5][31:16]};
        p6 = {{16{cal_shadow[REG_P6_P7][15]}}, cal_shadow[REG_P6_P7][15:0]};
        p7 = {{16{cal_shadow[REG_P6_P7][31]}}, cal_shadow[REG_P6_P7][31:16]};
        p8 = {{16{cal_shadow[REG_P8_P9][15]}}, cal_shadow[REG_P8_P9][15:0]};
        p9 = {{16{cal_shadow[REG_P8_P9][31]}}, cal_shadow[REG_P8_P9][31:16]};
        ut = {12'd0, s.raw_temp};
        up = {12'd0, s.raw_press};
        // temperature
        a = shr_s(mlo((ut >> 3) - (t1 << 1), t2), 11);
        d = (ut >> 4) - t1;
        b = shr_s(mlo(shr_s(mlo(d, d), 12), t3), 14);
        fine = a + b;
        temp = shr_s(mlo(fine, 32'd5) + 32'd128, 8);
        // pressure
        a = shr_s(fine, 1) - 32'd64000;
        q = shr_s(a, 2);
        qq = mlo(q, q);
        b = mlo(shr_s(qq, 11), p6);
        b = b + (mlo(a, p5) << 1);
        b = shr_s(b, 2) + (p4 << 16);
        a = shr_s(shr_s(mlo(p3, shr_s(qq, 13)), 3) + shr_s(mlo(p2, a), 1), 18);
        a = shr_s(mlo(32'd32768 + a, p1), 15);
        press = mlo((32'd1048576 - up) - shr_s(b, 12), 32'd3125);
        r.div_zero = 1'b0;
        if (a == 32'd0)
        begin
            press = 32'd0;
            r.div_zero = 1'b1;
        end
        else
        begin
            if (press < 32'h8000_0000)
                press = (press << 1) / a;
            else
                press = (press / a) << 1;
            sq = mlo(press >> 3, press >> 3) >> 13;
            a = shr_s(mlo(p9, sq), 12);
            b = shr_s(mlo(press >> 2, p8), 13);
            press = press + shr_s(a + b + p7, 4);
        end
        r.temperature = temp;
        r.fine_temp = fine;
        r.pressure = press;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s result %0d: got %h want %h", what, recv_count, got, want);
        err_count++;
    endtask

    // Drive samples from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (sample_q.size() > 0 && !cfg_busy &&
                $urandom_range(99, 0) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= sample_q[0];
                comp_expect_q.push_back(compensate(sample_q[0]));
                void'(sample_q.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure, with one long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HoldCycles - 1)
                hold_done <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Check results against the oldest expectation
    always @(posedge clk)
    begin
        comp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (comp_expect_q.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = comp_expect_q.pop_front();
                if (m_axis_tdata[31:0] !== want.temperature)
                    report_mismatch("temperature", m_axis_tdata[31:0], want.temperature);
                if (m_axis_tdata[63:32] !== want.fine_temp)
                    report_mismatch("fine_temp", m_axis_tdata[63:32], want.fine_temp);
                if (m_axis_tdata[95:64] !== want.pressure)
                    report_mismatch("pressure", m_axis_tdata[95:64], want.pressure);
                if (m_axis_tuser !== want.div_zero)
                    report_mismatch("div_zero", {31'd0, m_axis_tuser},
                                    {31'd0, want.div_zero});
                if (want.div_zero)
                    div_zero_count++;
            end
            recv_count++;
        end
    end

    // Watchdog on cycles without any transaction
    assign sent_fire = s_axis_tvalid && s_axis_tready;
    assign recv_fire = m_axis_tvalid && m_axis_tready;
    always @(posedge clk)
    begin
        if (sent_fire || recv_fire || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (sent_fire)
            sent_count <= sent_count + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("watchdog expired, %0d results pending", comp_expect_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cal_shadow[idx] = val;
    endtask

    // Wait for the pipeline to empty before touching the coefficients
    task automatic drain();
        while (sample_q.size() > 0 || s_axis_tvalid || comp_expect_q.size() > 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    task automatic push_sample(input logic [19:0] t, input logic [19:0] p);
        sample_t s;
        s.raw_temp = t;
        s.raw_press = p;
        sample_q.push_back(s);
    endtask

    task automatic load_typical();
        write_cal(REG_T1_T2, {16'd26435, 16'd27504});
        write_cal(REG_T3_P1, {16'd36477, 16'hFC18});
        write_cal(REG_P2_P3, {16'd3024, 16'hD5D0});
        write_cal(REG_P4_P5, {16'd140, 16'd2855});
        write_cal(REG_P6_P7, {16'd15500, 16'hFFF9});
        write_cal(REG_P8_P9, {16'd6000, 16'hC3B8});
    endtask

    task automatic load_random();
        for (int i = 0; i < NumCal; i++)
            write_cal(i[2:0], $urandom());
    endtask

    // Random phase, mostly realistic readings with some full-range noise
    task automatic random_phase(input int n, input int sidle, input int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3, 0) != 0)
                push_sample($urandom_range(560000, 480000), $urandom_range(460000, 260000));
            else
                push_sample($urandom_range(20'hFFFFF, 0), $urandom_range(20'hFFFFF, 0));
        end
        drain();
    endtask

    initial
    begin
        cfg_busy = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        for (int i = 0; i < NumCal; i++)
            cal_shadow[i] = 32'd0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients: divisor is zero
        cfg_busy = 1'b1;
        push_sample(20'd0, 20'd0);
        push_sample(20'hFFFFF, 20'hFFFFF);
        cfg_busy = 1'b0;
        drain();

        // Directed: typical coefficients, field extremes
        cfg_busy = 1'b1;
        load_typical();
        cfg_busy = 1'b0;
        push_sample(20'd519888, 20'd415148);
        push_sample(20'd0, 20'd0);
        push_sample(20'hFFFFF, 20'd0);
        push_sample(20'd0, 20'hFFFFF);
        push_sample(20'hFFFFF, 20'hFFFFF);
        push_sample(20'h55555, 20'hAAAAA);
        push_sample(20'hAAAAA, 20'h55555);
        push_sample(20'd500000, 20'd100);
        push_sample(20'd540000, 20'd1000000);
        drain();

        // Extreme coefficients: all ones, sign bits only, P1 zero
        cfg_busy = 1'b1;
        for (int i = 0; i < NumCal; i++)
            write_cal(i[2:0], 32'hFFFF_FFFF);
        cfg_busy = 1'b0;
        push_sample(20'd0, 20'd0);
        push_sample(20'hFFFFF, 20'hFFFFF);
        push_sample(20'd519888, 20'd415148);
        drain();
        cfg_busy = 1'b1;
        for (int i = 0; i < NumCal; i++)
            write_cal(i[2:0], 32'h8000_8000);
        cfg_busy = 1'b0;
        push_sample(20'd0, 20'hFFFFF);
        push_sample(20'hFFFFF, 20'd0);
        push_sample(20'd300000, 20'd300000);
        drain();
        cfg_busy = 1'b1;
        load_typical();
        write_cal(REG_T3_P1, 32'h0000_7FFF);
        cfg_busy = 1'b0;
        push_sample(20'd519888, 20'd415148);
        push_sample(20'hFFFFF, 20'd0);
        drain();

        // Random phases across idling mixes
        cfg_busy = 1'b1;
        load_typical();
        cfg_busy = 1'b0;
        random_phase(200, 0, 0);
        cfg_busy = 1'b1;
        load_random();
        cfg_busy = 1'b0;
        random_phase(150, 47, 0);
        cfg_busy = 1'b1;
        load_typical();
        cfg_busy = 1'b0;
        random_phase(150, 0, 47);
        cfg_busy = 1'b1;
        load_random();
        cfg_busy = 1'b0;
        random_phase(150, 24, 24);

        // Long receiver hold-off while samples keep coming
        cfg_busy = 1'b1;
        load_typical();
        cfg_busy = 1'b0;
        hold_req = 1'b1;
        random_phase(180, 0, 0);

        repeat (DrainCycles) @(posedge clk);
        $display("%0d samples sent, %0d results checked, %0d with zero divisor",
                 sent_count, recv_count, div_zero_count);
        $display("covered reset, typical, extreme and random coefficients under mixed stalls");
        if (err_count == 0 && comp_expect_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> baro_sensor_compensation.f
design/bsc_pkg.sv
design/bsc_div.sv
design/baro_sensor_compensation.sv
tb/tb_top.sv
